// ===== rtl/tdps_pkg.sv =====
// ----------------------------------------------------------------------------
// tdps_pkg
// Shared types and constants for the trial-division prime scanner.
// ----------------------------------------------------------------------------
package tdps_pkg;

    localparam int CAND_W = 16;
    localparam int CNT_W  = 17;
    localparam int SUM_W  = 18;

    // prime count saturates here
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h10000;

    typedef struct packed {
        logic [CAND_W-1:0] candidate;
        logic              restart;
    } item_t;

    typedef struct packed {
        logic              is_prime;
        logic [CNT_W-1:0]  prime_count;
        logic [SUM_W-1:0]  first_four_sum;
        logic [SUM_W-1:0]  last_four_sum;
        logic              sums_valid;
    } result_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_stat_t;

    // one tally update
    typedef struct packed {
        logic              restart;
        logic              prime;
        logic [CAND_W-1:0] value;
    } tally_in_t;

    // tally state after the update
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] first_sum;
        logic [SUM_W-1:0] recent_sum;
        logic             sums_valid;
    } tally_t;

endpackage

// ===== rtl/tdps_divider.sv =====
// ----------------------------------------------------------------------------
// tdps_divider
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdps_divider
    import tdps_pkg::*;
#(
    parameter int NB = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NB-1:0] dividend,
    input  logic [NB-1:0] divisor,
    output div_stat_t     stat
);

    localparam int CW = $clog2(NB);

    logic [NB-1:0] shift_reg, shift_next;
    logic [NB-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NB:0]   trial;

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shift_reg[NB-1]};
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CW'(NB - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = NB'(trial - {1'b0, divisor});
            else
                rem_next = NB'(trial);
            shift_next = {shift_reg[NB-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/tdps_tally.sv =====
// ----------------------------------------------------------------------------
// tdps_tally
// Range statistics: prime count, first-N sum, sliding window of recent primes.
// ----------------------------------------------------------------------------
module tdps_tally
    import tdps_pkg::*;
#(
    parameter int SUM_TERMS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      upd_en,
    input  tally_in_t upd,
    output tally_t    nxt
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next, base_cnt;
    logic [SUM_W-1:0]  first_reg, first_next, base_first;
    logic [SUM_W-1:0]  rsum_reg, rsum_next, base_rsum;
    logic [CAND_W-1:0] win_reg  [SUM_TERMS];
    logic [CAND_W-1:0] win_next [SUM_TERMS];
    logic [CAND_W-1:0] base_win [SUM_TERMS];

    always_comb
    begin
        base_cnt   = upd.restart ? '0 : cnt_reg;
        base_first = upd.restart ? '0 : first_reg;
        base_rsum  = upd.restart ? '0 : rsum_reg;
        for (int k = 0; k < SUM_TERMS; k++)
            base_win[k] = upd.restart ? '0 : win_reg[k];

        cnt_next   = base_cnt;
        first_next = base_first;
        rsum_next  = base_rsum;
        for (int k = 0; k < SUM_TERMS; k++)
            win_next[k] = base_win[k];

        if (upd.prime)
        begin
            if (base_cnt < CNT_W'(SUM_TERMS))
                first_next = base_first + SUM_W'(upd.value);
            rsum_next = base_rsum - SUM_W'(base_win[SUM_TERMS-1]) + SUM_W'(upd.value);
            win_next[0] = upd.value;
            for (int k = 1; k < SUM_TERMS; k++)
                win_next[k] = base_win[k-1];
            if (base_cnt != COUNT_MAX)
                cnt_next = base_cnt + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            first_reg <= '0;
            rsum_reg  <= '0;
            for (int k = 0; k < SUM_TERMS; k++)
                win_reg[k] <= '0;
        end
        else if (upd_en)
        begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            rsum_reg  <= rsum_next;
            for (int k = 0; k < SUM_TERMS; k++)
                win_reg[k] <= win_next[k];
        end
    end

    assign nxt.count      = cnt_next;
    assign nxt.first_sum  = first_next;
    assign nxt.recent_sum = rsum_next;
    assign nxt.sums_valid = (cnt_next >= CNT_W'(SUM_TERMS));

endmodule

// ===== rtl/trial_division_prime_scan.sv =====
// ----------------------------------------------------------------------------
// Each beat runs one remainder pass of NB = min(VALUE_BITS,16) bits for each
//   of its D trial divisors (2 up to floor(sqrt(n)) for a prime).
// One beat is handled at a time, and the bit-serial remainder unit takes most
//   of its time. A finished result may wait in the output register
//   while the next beat is taken.
// Reset: rst_n clears count, sums, window and handshake state at once.
// ----------------------------------------------------------------------------
// trial_division_prime_scan
// Trial-division primality test over a scanned range with running statistics.
// ----------------------------------------------------------------------------
module trial_division_prime_scan
    import tdps_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int SUM_TERMS  = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Only the low bits of the candidate up to the field width take part.
    localparam int NB  = (VALUE_BITS < CAND_W) ? VALUE_BITS : CAND_W;
    localparam int SQW = NB + 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Working registers for the beat under test
    logic [NB-1:0]  n_reg, n_next;
    logic           restart_reg, restart_next;
    logic [NB-1:0]  d_reg, d_next;       // current trial divisor
    logic [SQW-1:0] sq_reg, sq_next;     // d*d, kept by increments
    logic           prime_reg, prime_next;

    logic           res_valid_reg, res_valid_next;
    result_t        res_reg, res_next;

    logic           div_start;
    div_stat_t      div_stat;
    logic           tally_en;
    tally_in_t      tally_upd;
    tally_t         tally_nxt;
    logic           out_free;

    assign out_free   = !res_valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        restart_next   = restart_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        div_start      = 1'b0;
        tally_en       = 1'b0;

        if (res_valid_reg && result_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    n_next       = item.candidate[NB-1:0];
                    restart_next = item.restart;
                    d_next       = NB'(2);
                    sq_next      = SQW'(4);
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // zero and one are not prime; otherwise stop once d*d exceeds n
                if (n_reg <= NB'(1))
                begin
                    prime_next = 1'b0;
                    state_next = S_DONE;
                end
                else if (sq_reg > SQW'(n_reg))
                begin
                    prime_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + SQW'({d_reg, 1'b1});
                        d_next     = d_reg + 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_DONE:
            begin
                // statistics commit together with the result beat
                if (out_free)
                begin
                    tally_en                = 1'b1;
                    res_next.is_prime       = prime_reg;
                    res_next.prime_count    = tally_nxt.count;
                    res_next.first_four_sum = tally_nxt.first_sum;
                    res_next.last_four_sum  = tally_nxt.recent_sum;
                    res_next.sums_valid     = tally_nxt.sums_valid;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        restart_reg <= restart_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        prime_reg   <= prime_next;
        res_reg     <= res_next;
    end

    tdps_divider #(
        .NB (NB)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .stat     (div_stat)
    );

    assign tally_upd.restart = restart_reg;
    assign tally_upd.prime   = prime_reg;
    assign tally_upd.value   = CAND_W'(n_reg);

    tdps_tally #(
        .SUM_TERMS (SUM_TERMS)
    ) u_tally (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (tally_en),
        .upd    (tally_upd),
        .nxt    (tally_nxt)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
